// ===== design/aigsim_pkg.sv =====
// ----------------------------------------------------------------------------
// aigsim_pkg
// Shared constants, codes and controller/datapath interface types of the
// and-inverter graph bit-parallel simulator.
// ----------------------------------------------------------------------------
package aigsim_pkg;

	localparam int MAX_NODES = 1024;
	localparam int NODE_W    = $clog2(MAX_NODES);
	localparam int LIT_W     = NODE_W + 1;
	localparam int PAT_W     = 32;
	localparam int CNT_W     = 10;
	localparam int OP_W      = 2;
	localparam int FAN_W     = 2 * LIT_W;

	// slave tdata: left, right, pattern, query, zero fill
	localparam int S_FIELDS_W = 3 * LIT_W + PAT_W;
	localparam int S_DATA_W   = ((S_FIELDS_W + 7) / 8) * 8;
	// master tdata: literal value, echoed literal, zero fill
	localparam int M_FIELDS_W = PAT_W + LIT_W;
	localparam int M_DATA_W   = ((M_FIELDS_W + 7) / 8) * 8;

	localparam int CFG_IDX_W  = 1;

	localparam logic [CFG_IDX_W-1:0] CFG_INPUT_COUNT = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_GATE_COUNT  = 1'b1;

	typedef enum logic [OP_W-1:0] {
		OP_LOAD  = 2'd0,
		OP_INPUT = 2'd1,
		OP_QUERY = 2'd2
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_QUERY,
		ST_FETCH,
		ST_READ,
		ST_WRITE
	} state_t;

	typedef struct packed {
		logic load_we;
		logic in_we;
		logic eval_init;
		logic fetch;
		logic node_rd;
		logic node_wr;
		logic q_rd;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic eval_go;
		logic gate_end;
		logic out_free;
	} sts_t;

endpackage

// ===== design/aigsim_ctrl.sv =====
// ----------------------------------------------------------------------------
// aigsim_ctrl
// Controller: accepts words, sequences the gate evaluation pass and the
// query read, and issues commands to the datapath.
// ----------------------------------------------------------------------------
module aigsim_ctrl (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	input  logic [aigsim_pkg::OP_W-1:0]     op,
	input  aigsim_pkg::sts_t                sts,
	output aigsim_pkg::cmd_t                cmd
);

	aigsim_pkg::state_t state_q;
	aigsim_pkg::state_t state_nxt;
	logic               accept;

	assign s_axis_tready = (state_q == aigsim_pkg::ST_IDLE);
	assign accept        = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= aigsim_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			aigsim_pkg::ST_IDLE: begin
				if (accept) begin
					unique case (op)
						aigsim_pkg::OP_INPUT: begin
							if (sts.eval_go) begin
								state_nxt = aigsim_pkg::ST_FETCH;
							end
						end
						aigsim_pkg::OP_QUERY: state_nxt = aigsim_pkg::ST_QUERY;
						default: state_nxt = aigsim_pkg::ST_IDLE;
					endcase
				end
			end
			aigsim_pkg::ST_QUERY: begin
				if (sts.out_free) begin
					state_nxt = aigsim_pkg::ST_IDLE;
				end
			end
			aigsim_pkg::ST_FETCH: begin
				if (sts.gate_end) begin
					state_nxt = aigsim_pkg::ST_IDLE;
				end else begin
					state_nxt = aigsim_pkg::ST_READ;
				end
			end
			aigsim_pkg::ST_READ:  state_nxt = aigsim_pkg::ST_WRITE;
			aigsim_pkg::ST_WRITE: state_nxt = aigsim_pkg::ST_FETCH;
			default:              state_nxt = aigsim_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		unique case (state_q)
			aigsim_pkg::ST_IDLE: begin
				if (accept) begin
					cmd.load_we   = (op == aigsim_pkg::OP_LOAD);
					cmd.in_we     = (op == aigsim_pkg::OP_INPUT);
					cmd.eval_init = (op == aigsim_pkg::OP_INPUT) && sts.eval_go;
					cmd.q_rd      = (op == aigsim_pkg::OP_QUERY);
				end
			end
			aigsim_pkg::ST_QUERY: cmd.out_load = sts.out_free;
			aigsim_pkg::ST_FETCH: cmd.fetch    = !sts.gate_end;
			aigsim_pkg::ST_READ:  cmd.node_rd  = 1'b1;
			aigsim_pkg::ST_WRITE: cmd.node_wr  = 1'b1;
			default: cmd = '0;
		endcase
	end

	ast_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.load_we, cmd.in_we, cmd.q_rd, cmd.fetch, cmd.node_rd,
			cmd.node_wr, cmd.out_load}))
		else $error("more than one datapath command at once");
	ast_read_write: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.node_rd |=> cmd.node_wr)
		else $error("node read not followed by gate write");
	ast_init_fetch: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.eval_init |=> state_q == aigsim_pkg::ST_FETCH)
		else $error("evaluation start did not enter fetch");

endmodule

// ===== design/aigsim_datapath.sv =====
// ----------------------------------------------------------------------------
// aigsim_datapath
// Datapath: configuration registers, fanin and node value memories, load and
// input pointers, gate evaluation and the output register.
// ----------------------------------------------------------------------------
module aigsim_datapath (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [aigsim_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [aigsim_pkg::CNT_W-1:0]         cfg_data,
	input  logic [aigsim_pkg::S_DATA_W-1:0]      s_data,
	input  aigsim_pkg::cmd_t                     cmd,
	output aigsim_pkg::sts_t                     sts,
	output logic                                 m_axis_tvalid,
	input  logic                                 m_axis_tready,
	output logic [aigsim_pkg::M_DATA_W-1:0]      m_axis_tdata
);

	localparam int LW = aigsim_pkg::LIT_W;
	localparam int NW = aigsim_pkg::NODE_W;
	localparam int PW = aigsim_pkg::PAT_W;
	localparam int CW = aigsim_pkg::CNT_W;

	logic [CW-1:0]                 in_cnt_q;
	logic [CW-1:0]                 gate_cnt_q;
	logic [CW-1:0]                 ld_ptr_q;
	logic [CW-1:0]                 in_ptr_q;
	logic [CW-1:0]                 gate_q;
	logic [NW:0]                   node_q;
	logic [aigsim_pkg::FAN_W-1:0]  fan_q;
	logic [PW-1:0]                 rda_q;
	logic [PW-1:0]                 rdb_q;
	logic [LW-1:0]                 lita_q;
	logic [LW-1:0]                 litb_q;
	logic                          out_valid_q;
	logic [PW-1:0]                 out_value_q;
	logic [LW-1:0]                 out_lit_q;

	logic [aigsim_pkg::FAN_W-1:0]  gate_mem [aigsim_pkg::MAX_NODES];
	logic [PW-1:0]                 node_mem [aigsim_pkg::MAX_NODES];

	logic [LW-1:0]                 left_lit;
	logic [LW-1:0]                 right_lit;
	logic [PW-1:0]                 pattern;
	logic [LW-1:0]                 query_lit;
	logic                          in_store;
	logic [CW-1:0]                 in_next;
	logic [CW-1:0]                 ld_base;
	logic [CW-1:0]                 ld_inc;
	logic [CW-1:0]                 ld_next;
	logic                          ld_en;
	logic                          rd_a_en;
	logic [LW-1:0]                 rd_a_lit;
	logic                          node_we;
	logic [NW-1:0]                 node_wa;
	logic [PW-1:0]                 node_wd;
	logic [PW-1:0]                 gate_val;

	function automatic logic [PW-1:0] lit_val(input logic [LW-1:0] lit,
		input logic [PW-1:0] word);
		logic [PW-1:0] v;
		v = (lit[LW-1:1] == '0) ? '0 : word;
		return v ^ {PW{lit[0]}};
	endfunction

	assign left_lit  = s_data[LW-1:0];
	assign right_lit = s_data[2*LW-1:LW];
	assign pattern   = s_data[2*LW+PW-1:2*LW];
	assign query_lit = s_data[3*LW+PW-1:2*LW+PW];

	assign in_store = (in_ptr_q < in_cnt_q);
	assign in_next  = in_store ? in_ptr_q + 1'b1 : in_ptr_q;
	assign ld_base  = (ld_ptr_q >= gate_cnt_q) ? '0 : ld_ptr_q;
	assign ld_inc   = ld_base + 1'b1;
	assign ld_next  = (ld_inc >= gate_cnt_q) ? '0 : ld_inc;
	assign ld_en    = cmd.load_we && (gate_cnt_q != '0);

	assign sts.eval_go  = (in_next >= in_cnt_q);
	assign sts.gate_end = (gate_q == gate_cnt_q) || node_q[NW];
	assign sts.out_free = !out_valid_q || m_axis_tready;

	assign rd_a_en  = cmd.node_rd || cmd.q_rd;
	assign rd_a_lit = cmd.node_rd ? fan_q[2*LW-1:LW] : query_lit;

	assign gate_val = lit_val(lita_q, rda_q) & lit_val(litb_q, rdb_q);
	assign node_we  = (cmd.in_we && in_store) || cmd.node_wr;
	assign node_wa  = cmd.node_wr ? node_q[NW-1:0] : in_next;
	assign node_wd  = cmd.node_wr ? gate_val : pattern;

	// fanin store
	always_ff @(posedge clk) begin
		if (ld_en) begin
			gate_mem[ld_base] <= {left_lit, right_lit};
		end
		if (cmd.fetch) begin
			fan_q <= gate_mem[gate_q];
		end
	end

	// node value store
	always_ff @(posedge clk) begin
		if (node_we) begin
			node_mem[node_wa] <= node_wd;
		end
		if (rd_a_en) begin
			rda_q <= node_mem[rd_a_lit[LW-1:1]];
		end
		if (cmd.node_rd) begin
			rdb_q <= node_mem[fan_q[LW-1:1]];
		end
	end

	always_ff @(posedge clk) begin
		if (rd_a_en) begin
			lita_q <= rd_a_lit;
		end
		if (cmd.node_rd) begin
			litb_q <= fan_q[LW-1:0];
		end
		if (cmd.out_load) begin
			out_value_q <= lit_val(lita_q, rda_q);
			out_lit_q   <= lita_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_cnt_q    <= '0;
			gate_cnt_q  <= '0;
			ld_ptr_q    <= '0;
			in_ptr_q    <= '0;
			gate_q      <= '0;
			node_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					aigsim_pkg::CFG_INPUT_COUNT: in_cnt_q   <= cfg_data;
					aigsim_pkg::CFG_GATE_COUNT:  gate_cnt_q <= cfg_data;
					default: ;
				endcase
			end
			if (ld_en) begin
				ld_ptr_q <= ld_next;
			end
			if (cmd.in_we) begin
				in_ptr_q <= sts.eval_go ? '0 : in_next;
			end
			if (cmd.eval_init) begin
				gate_q <= '0;
				node_q <= {1'b0, in_cnt_q} + 1'b1;
			end else if (cmd.node_wr) begin
				gate_q <= gate_q + 1'b1;
				node_q <= node_q + 1'b1;
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{(aigsim_pkg::M_DATA_W - aigsim_pkg::M_FIELDS_W){1'b0}},
		out_lit_q, out_value_q};

	ast_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid_q || m_axis_tready))
		else $error("result word overwritten before it was taken");
	ast_gate_node: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.node_wr |-> (node_q != '0) && !node_q[NW])
		else $error("gate write outside the node range");
	ast_ld_ptr: assert property (@(posedge clk) disable iff (!arst_n)
		ld_en |=> (ld_ptr_q < $past(gate_cnt_q)))
		else $error("load pointer left the gate range");

endmodule

// ===== design/aig_bit_parallel_simulator_unit.sv =====
// ----------------------------------------------------------------------------
// aig_bit_parallel_simulator_unit
// And-inverter graph simulator over 32 patterns at once: gate fanin load,
// input pattern words, in-order gate evaluation and literal queries.
//
//   channel  direction  tdata (low bit up)                     tuser
//   s_axis   in         left, right, pattern word, query lit   op
//   m_axis   out        literal value, echoed literal          -
//   cfg      in         input_count / gate_count write         -
//
// load and input words leave tready high; a query goes through the node memory
// read, then the output register
// the word that completes the inputs holds tready low while each gate is
// evaluated in turn: fanin read, two-port node read, and-and-write
// a waiting result holds a following query but not loads or input words
// reset clears counts and pointers; the memories are not cleared
// ----------------------------------------------------------------------------
module aig_bit_parallel_simulator_unit (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [aigsim_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [aigsim_pkg::CNT_W-1:0]         cfg_data,
	input  logic                                 s_axis_tvalid,
	output logic                                 s_axis_tready,
	// left_literal, right_literal, pattern_word, query_literal, zero fill
	input  logic [aigsim_pkg::S_DATA_W-1:0]      s_axis_tdata,
	// op
	input  logic [aigsim_pkg::OP_W-1:0]          s_axis_tuser,
	output logic                                 m_axis_tvalid,
	input  logic                                 m_axis_tready,
	// literal_value, echoed_literal, zero fill
	output logic [aigsim_pkg::M_DATA_W-1:0]      m_axis_tdata
);

	aigsim_pkg::cmd_t cmd;
	aigsim_pkg::sts_t sts;

	aigsim_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.op            (s_axis_tuser),
		.sts           (sts),
		.cmd           (cmd)
	);

	aigsim_datapath u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_data        (s_axis_tdata),
		.cmd           (cmd),
		.sts           (sts),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

endmodule

// ===== tb/aigsim_query_checker.sv =====
// ----------------------------------------------------------------------------
// aigsim_query_checker
// Watches the configuration port and both stream channels of the and-inverter
// graph simulator. Keeps its own copy of the graph, the node words and the
// load and input pointers, works out the answer to every accepted query and
// compares each returned word, field by field, against the oldest answer
// still waiting.
// ----------------------------------------------------------------------------
module aigsim_query_checker (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [aigsim_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [aigsim_pkg::CNT_W-1:0]         cfg_data,
	input  logic                                 s_axis_tvalid,
	input  logic                                 s_axis_tready,
	input  logic [aigsim_pkg::S_DATA_W-1:0]      s_axis_tdata,
	input  logic [aigsim_pkg::OP_W-1:0]          s_axis_tuser,
	input  logic                                 m_axis_tvalid,
	input  logic                                 m_axis_tready,
	input  logic [aigsim_pkg::M_DATA_W-1:0]      m_axis_tdata,
	output int                                   mismatches,
	output int                                   awaiting
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LW    = aigsim_pkg::LIT_W;
	localparam int PW    = aigsim_pkg::PAT_W;
	localparam int NW    = aigsim_pkg::NODE_W;
	localparam int FW    = aigsim_pkg::FAN_W;
	localparam int NODES = aigsim_pkg::MAX_NODES;

	typedef struct {
		logic [PW-1:0] value;
		logic [LW-1:0] literal;
	} read_t;

	read_t         expected_reads[$];
	logic [FW-1:0] fanin_mem[NODES];
	logic [PW-1:0] value_mem[NODES];
	int            n_inputs;
	int            n_gates;
	int            load_ptr;
	int            in_ptr;

	initial begin
		mismatches = 0;
		awaiting   = 0;
	end

	function automatic logic [PW-1:0] literal_word(input logic [LW-1:0] lit);
		logic [NW-1:0] node;
		logic [PW-1:0] v;
		node = lit[LW-1:1];
		v = (node == '0) ? '0 : value_mem[node];
		return lit[0] ? ~v : v;
	endfunction

	function automatic void run_gates();
		int            g;
		logic [FW-1:0] f;
		for (g = 0; g < n_gates && n_inputs + 1 + g < NODES; g++) begin
			f = fanin_mem[g];
			value_mem[n_inputs + 1 + g] = literal_word(f[FW-1:LW])
				& literal_word(f[LW-1:0]);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		logic [LW-1:0] l;
		logic [LW-1:0] r;
		logic [PW-1:0] pat;
		logic [LW-1:0] q;
		read_t         exp_read;
		logic [PW-1:0] got_value;
		logic [LW-1:0] got_literal;
		if (!arst_n) begin
			n_inputs = 0;
			n_gates  = 0;
			load_ptr = 0;
			in_ptr   = 0;
			awaiting <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					aigsim_pkg::CFG_INPUT_COUNT: n_inputs = int'(cfg_data);
					aigsim_pkg::CFG_GATE_COUNT:  n_gates  = int'(cfg_data);
					default: ;
				endcase
			end
			if (m_axis_tvalid && m_axis_tready) begin
				got_value   = m_axis_tdata[PW-1:0];
				got_literal = m_axis_tdata[PW +: LW];
				if (expected_reads.size() == 0) begin
					$error("result with no query waiting: literal_value %h, echoed_literal %h",
						got_value, got_literal);
					mismatches++;
				end else begin
					exp_read = expected_reads.pop_front();
					if (got_value !== exp_read.value) begin
						$error("literal_value: expected %h, got %h", exp_read.value, got_value);
						mismatches++;
					end
					if (got_literal !== exp_read.literal) begin
						$error("echoed_literal: expected %0d, got %0d",
							exp_read.literal, got_literal);
						mismatches++;
					end
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				l   = s_axis_tdata[LW-1:0];
				r   = s_axis_tdata[LW +: LW];
				pat = s_axis_tdata[2*LW +: PW];
				q   = s_axis_tdata[2*LW+PW +: LW];
				case (s_axis_tuser)
					aigsim_pkg::OP_LOAD: begin
						if (n_gates != 0) begin
							if (load_ptr >= n_gates)
								load_ptr = 0;
							fanin_mem[load_ptr] = {l, r};
							load_ptr++;
							if (load_ptr >= n_gates)
								load_ptr = 0;
						end
					end
					aigsim_pkg::OP_INPUT: begin
						if (in_ptr < n_inputs) begin
							value_mem[in_ptr + 1] = pat;
							in_ptr++;
						end
						if (in_ptr >= n_inputs) begin
							run_gates();
							in_ptr = 0;
						end
					end
					aigsim_pkg::OP_QUERY: begin
						exp_read.value   = literal_word(q);
						exp_read.literal = q;
						expected_reads   = {expected_reads, exp_read};
					end
					default: ;
				endcase
			end
			awaiting <= expected_reads.size();
		end
	end

endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the and-inverter graph simulator. A short directed
// run covers empty graphs, constant literals, both pointer wrap-arounds,
// extreme pattern words and one long output stall; then random graphs are
// loaded, simulated and queried over nodes already written, with broken
// input runs, unused op codes and random idling on both channels.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LW    = aigsim_pkg::LIT_W;
	localparam int PW    = aigsim_pkg::PAT_W;
	localparam int CW    = aigsim_pkg::CNT_W;
	localparam int SW    = aigsim_pkg::S_DATA_W;
	localparam int NODES = aigsim_pkg::MAX_NODES;

	localparam logic [aigsim_pkg::OP_W-1:0] OP_UNUSED   = 2'd3;
	localparam int                          STALL_LIMIT = 20000;
	localparam int                          ITEMS       = 850;

	logic                                clk           = 1'b0;
	logic                                arst_n        = 1'b0;
	logic                                cfg_we        = 1'b0;
	logic [aigsim_pkg::CFG_IDX_W-1:0]    cfg_index     = '0;
	logic [CW-1:0]                       cfg_data      = '0;
	logic                                s_axis_tvalid = 1'b0;
	logic                                s_axis_tready;
	logic [SW-1:0]                       s_axis_tdata  = '0;
	logic [aigsim_pkg::OP_W-1:0]         s_axis_tuser  = '0;
	logic                                m_axis_tvalid;
	logic                                m_axis_tready = 1'b0;
	logic [aigsim_pkg::M_DATA_W-1:0]     m_axis_tdata;

	int mismatches;
	int awaiting;
	int cur_ni       = 0;
	int cur_ng       = 0;
	int ld_at        = 0;
	int in_at        = 0;
	int filled       = 0;
	int items_sent   = 0;
	int idle_cycles  = 0;
	bit calm         = 1'b0;
	bit no_idle      = 1'b0;
	bit squeeze_req  = 1'b0;
	bit squeeze_done = 1'b0;

	aig_bit_parallel_simulator_unit DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	aigsim_query_checker u_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.mismatches    (mismatches),
		.awaiting      (awaiting)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= STALL_LIMIT) begin
			$display("** aig_bit_parallel_simulator_unit: FAILED **");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		@(posedge clk);
		forever begin
			if (squeeze_req && !squeeze_done) begin
				squeeze_done = 1'b1;
				m_axis_tready <= 1'b0;
				repeat (300) @(posedge clk);
			end else if (!no_idle && !calm && $urandom_range(5) == 0) begin
				m_axis_tready <= 1'b0;
				repeat ($urandom_range(5, 1)) @(posedge clk);
			end else begin
				m_axis_tready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	function automatic logic [LW-1:0] some_literal();
		return LW'($urandom_range(2 * NODES - 1));
	endfunction

	// literal on a node that already holds a word
	function automatic logic [LW-1:0] known_literal();
		return LW'($urandom_range(2 * filled + 1));
	endfunction

	function automatic logic [PW-1:0] some_pattern();
		case ($urandom_range(7))
			0:       return '0;
			1:       return '1;
			default: return $urandom;
		endcase
	endfunction

	// gate slot the next load word lands in
	function automatic int next_gate();
		int g;
		if (cur_ng == 0)
			return 0;
		if (ld_at >= cur_ng)
			ld_at = 0;
		g = ld_at;
		ld_at = (ld_at + 1 >= cur_ng) ? 0 : ld_at + 1;
		return g;
	endfunction

	task automatic send(input logic [aigsim_pkg::OP_W-1:0] op, input logic [LW-1:0] l,
			input logic [LW-1:0] r, input logic [PW-1:0] pat, input logic [LW-1:0] q);
		if (!no_idle && !calm && $urandom_range(3) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(5, 1)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= op;
		s_axis_tdata  <= SW'({q, pat, r, l});
		do @(posedge clk); while (!s_axis_tready);
		if (op != OP_UNUSED)
			items_sent++;
	endtask

	task automatic query(input logic [LW-1:0] q);
		send(aigsim_pkg::OP_QUERY, some_literal(), some_literal(), some_pattern(), q);
	endtask

	task automatic load(input logic [LW-1:0] l, input logic [LW-1:0] r);
		void'(next_gate());
		send(aigsim_pkg::OP_LOAD, l, r, some_pattern(), some_literal());
	endtask

	// input word, keeping track of which nodes hold a word
	task automatic input_word(input logic [PW-1:0] pat);
		int top;
		send(aigsim_pkg::OP_INPUT, some_literal(), some_literal(), pat, some_literal());
		if (in_at < cur_ni)
			in_at++;
		if (in_at > filled)
			filled = in_at;
		if (in_at >= cur_ni) begin
			top = (cur_ni + cur_ng < NODES - 1) ? cur_ni + cur_ng : NODES - 1;
			if (top > filled)
				filled = top;
			in_at = 0;
		end
	endtask

	// stray query or unused op code between words of a run
	task automatic interject();
		if ($urandom_range(7) == 0)
			query(known_literal());
		else if ($urandom_range(19) == 0)
			send(OP_UNUSED, some_literal(), some_literal(), some_pattern(), some_literal());
	endtask

	task automatic settle();
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (awaiting != 0);
		repeat (3 * cur_ng + 8) @(posedge clk);
	endtask

	task automatic configure(input int ni, input int ng);
		settle();
		cfg_we    <= 1'b1;
		cfg_index <= aigsim_pkg::CFG_INPUT_COUNT;
		cfg_data  <= CW'(ni);
		@(posedge clk);
		cfg_index <= aigsim_pkg::CFG_GATE_COUNT;
		cfg_data  <= CW'(ng);
		@(posedge clk);
		cfg_we <= 1'b0;
		cur_ni = ni;
		cur_ng = ng;
	endtask

	initial begin : stimulus
		int            ni;
		int            ng;
		int            loads;
		int            passes;
		int            words;
		int            g;
		int            hi;
		int            top;
		bit            big;
		logic [LW-1:0] q;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty graph: loads ignored, every input word evaluates at once
		load(11'd2, 11'd4);
		send(OP_UNUSED, some_literal(), some_literal(), some_pattern(), some_literal());
		input_word('1);
		query(11'd0);
		query(11'd1);

		configure(2, 2);
		load(11'd2, 11'd5);
		load(11'd7, 11'd1);
		input_word(32'hffff_ffff);
		input_word(32'h0000_0000);
		query(11'd6);
		query(11'd7);
		query(11'd8);
		query(11'd9);
		input_word(32'ha5a5_a5a5);
		input_word(32'h3c3c_0ff0);
		query(11'd9);
		query(11'd2);

		// load pointer left past a shrunk gate count
		load(11'd4, 11'd4);
		configure(2, 1);
		load(11'd2, 11'd4);
		input_word($urandom);
		input_word($urandom);
		query(11'd6);

		// input pointer left past a shrunk input count
		configure(3, 0);
		input_word($urandom);
		input_word($urandom);
		configure(1, 0);
		input_word($urandom);
		query(11'd4);
		query(11'd5);

		// long output stall while queries keep coming
		calm = 1'b1;
		squeeze_req = 1'b1;
		repeat (60) query(known_literal());
		calm = 1'b0;

		while (items_sent < ITEMS) begin
			if (items_sent >= ITEMS - 100)
				no_idle = 1'b1;
			big = (items_sent < ITEMS - 400);
			ni = (big && $urandom_range(9) == 0) ? $urandom_range(120) : $urandom_range(12);
			ng = (big && $urandom_range(9) == 0) ? $urandom_range(200) : $urandom_range(30);
			configure(ni, ng);
			calm = ($urandom_range(3) == 0);
			loads = ng + (($urandom_range(4) == 0) ? $urandom_range(3, 1) : 0);
			for (int i = 0; i < loads; i++) begin
				interject();
				g = next_gate();
				hi = 2 * ((ni + g > filled) ? ni + g : filled) + 1;
				send(aigsim_pkg::OP_LOAD, LW'($urandom_range(hi)), LW'($urandom_range(hi)),
					some_pattern(), some_literal());
			end
			passes = $urandom_range(3, 1);
			for (int p = 0; p < passes; p++) begin
				words = (ni == 0) ? 1 : ni;
				if (p == passes - 1 && $urandom_range(5) == 0)
					words = $urandom_range(ni);
				for (int w = 0; w < words; w++) begin
					interject();
					input_word(some_pattern());
				end
				repeat ($urandom_range(6, 1)) begin
					q = known_literal();
					top = (ni + ng < filled) ? ni + ng : filled;
					if (ng > 0 && top > ni && $urandom_range(1) == 0)
						q = LW'($urandom_range(2 * top + 1, 2 * (ni + 1)));
					query(q);
				end
			end
		end

		settle();
		if (mismatches == 0)
			$display("** aig_bit_parallel_simulator_unit: PASSED **");
		else
			$display("** aig_bit_parallel_simulator_unit: FAILED **");
		$finish;
	end

endmodule
